/* rtl/core/binary_image_bbox_center_assert.svh */
// assertion macros for the bitmap bounding-box centre block
`ifndef BINARY_IMAGE_BBOX_CENTER_ASSERT_SVH
`define BINARY_IMAGE_BBOX_CENTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BIBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BIBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bibc_pkg.sv */
// types, constants and helpers for the bitmap bounding-box centre block
`timescale 1ns / 1ps
package bibc_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned COL_W   = 9;
  localparam int unsigned WIDTH_W = 13;

  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 13'd32;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [WIDTH_W-1:0] width_t;

  // zero counts as one pixel, anything above the cap saturates
  function automatic width_t eff_width(input width_t w, input width_t cap);
    width_t r;
    r = w;
    if (r == '0) r = width_t'(1);
    if (r > cap) r = cap;
    return r;
  endfunction

  // last byte column of a row padded to 32-bit words
  function automatic col_t last_col(input width_t w);
    width_t     words;
    logic [9:0] bytes_m1;
    words    = (w + width_t'(31)) >> 5;
    bytes_m1 = {words[7:0], 2'b00} - 10'd1;
    return bytes_m1[COL_W-1:0];
  endfunction

endpackage

/* rtl/core/bibc_if.sv */
// channel interfaces for the bitmap bounding-box centre block
`timescale 1ns / 1ps
interface bibc_in_if import bibc_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_byte;
  logic frame_end;
  modport source (output valid, output pixel_byte, output frame_end, input ready);
  modport sink   (input valid, input pixel_byte, input frame_end, output ready);
endinterface

interface bibc_out_if import bibc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t mid_x;
  coord_t mid_y;
  logic   found;
  modport source (output valid, output mid_x, output mid_y, output found,
                  input ready);
  modport sink   (input valid, input mid_x, input mid_y, input found,
                  output ready);
endinterface

interface bibc_cfg_if import bibc_pkg::*; ();
  logic   valid;
  logic   ready;
  width_t width_pixels;
  modport source (output valid, output width_pixels, input ready);
  modport sink   (input valid, input width_pixels, output ready);
endinterface

/* rtl/core/binary_image_bbox_center.sv */
// top level: bounding-box centre of a streamed 1-bit bitmap
//
//   channel | dir | payload                          | transfer
//   --------+-----+----------------------------------+-------------------
//   in_ch   | in  | pixel_byte[7:0], frame_end       | valid && ready
//   out_ch  | out | mid_x[11:0], mid_y[11:0],        | valid && ready
//           |     | found                            |
//   cfg_ch  | in  | width_pixels[12:0]               | valid && ready
//
// one byte per cycle sustained while no frame_end byte waits on a stalled
// result; a byte is registered on transfer and then folded into the running
// bounds; a frame_end byte loads the result register as it leaves the input stage
// the result register holds one frame result; only a frame_end byte waits
// on it, ordinary bytes pass while a result is stalled
// synchronous active-low reset clears bounds, counters and width (32 pixels)
// cfg_ch is always ready; the user must write it only while the block is idle, the block itself does not enforce this
`timescale 1ns / 1ps
`include "binary_image_bbox_center_assert.svh"
module binary_image_bbox_center
  import bibc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  bibc_in_if.sink     in_ch,
  bibc_out_if.source  out_ch,
  bibc_cfg_if.sink    cfg_ch
);

  // width saturates at the smaller of the parameter and the 12-bit x range
  localparam width_t WIDTH_CAP = width_t'((MAX_WIDTH < 4096) ? MAX_WIDTH : 4096);
  localparam coord_t LAST_ROW  = coord_t'(((MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096) - 1);

  // configuration: keep the effective width and the last byte column of a row
  width_t eff_w_r;
  col_t   last_col_r;
  width_t cfg_eff_w;

  assign cfg_ch.ready = 1'b1;
  assign cfg_eff_w    = eff_width(cfg_ch.width_pixels, WIDTH_CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r    <= eff_width(RESET_WIDTH, WIDTH_CAP);
      last_col_r <= last_col(eff_width(RESET_WIDTH, WIDTH_CAP));
    end else if (cfg_ch.valid) begin
      eff_w_r    <= cfg_eff_w;
      last_col_r <= last_col(cfg_eff_w);
    end
  end

  // input register stage
  logic s1_valid_r;
  pix_t s1_pix_r;
  logic s1_fend_r;
  logic s1_adv;
  logic in_xfer;

  logic out_valid_r;
  coord_t out_cx_r;
  coord_t out_cy_r;
  logic out_found_r;

  // a frame_end byte needs a free result slot, other bytes never stall
  assign s1_adv      = s1_valid_r && (!s1_fend_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_r  <= in_ch.pixel_byte;
      s1_fend_r <= in_ch.frame_end;
    end
  end

  // running frame state
  col_t   col_r,   col_nxt;
  coord_t row_r,   row_nxt;
  coord_t min_x_r, min_x_nxt;
  coord_t max_x_r, max_x_nxt;
  coord_t min_y_r, min_y_nxt;
  coord_t max_y_r, max_y_nxt;
  logic   any_r,   any_nxt;

  // pixel hits of the current byte: offset 0 is bit 7, padding masked off
  coord_t     x_base;
  logic [7:0] hit;
  logic [2:0] first_off;
  logic [2:0] last_off;
  coord_t     byte_min_x;
  coord_t     byte_max_x;
  logic       byte_hit;

  assign x_base = {col_r, 3'b000};

  always_comb begin
    hit       = '0;
    first_off = '0;
    last_off  = '0;
    for (int b = 0; b < 8; b++) begin
      hit[b] = s1_pix_r[7 - b] && (({1'b0, x_base} + width_t'(b)) < eff_w_r);
    end
    // scan right to left so the leftmost hit is kept
    for (int b = 7; b >= 0; b--) begin
      if (hit[b]) first_off = 3'(b);
    end
    for (int b = 0; b < 8; b++) begin
      if (hit[b]) last_off = 3'(b);
    end
  end

  assign byte_hit   = |hit;
  assign byte_min_x = x_base | coord_t'(first_off);
  assign byte_max_x = x_base | coord_t'(last_off);

  // bounds after folding in this byte
  coord_t upd_min_x, upd_max_x, upd_min_y, upd_max_y;
  logic   upd_any;

  always_comb begin
    upd_min_x = min_x_r;
    upd_max_x = max_x_r;
    upd_min_y = min_y_r;
    upd_max_y = max_y_r;
    upd_any   = any_r;
    if (byte_hit) begin
      if (byte_min_x < min_x_r) upd_min_x = byte_min_x;
      if (byte_max_x > max_x_r) upd_max_x = byte_max_x;
      if (row_r < min_y_r)      upd_min_y = row_r;
      if (row_r > max_y_r)      upd_max_y = row_r;
      upd_any = 1'b1;
    end
  end

  // next state: fold the byte in and advance position, or clear everything after the frame end
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    min_x_nxt = min_x_r;
    max_x_nxt = max_x_r;
    min_y_nxt = min_y_r;
    max_y_nxt = max_y_r;
    any_nxt   = any_r;
    if (s1_adv) begin
      if (s1_fend_r) begin
        col_nxt   = '0;
        row_nxt   = '0;
        min_x_nxt = '1;
        max_x_nxt = '0;
        min_y_nxt = '1;
        max_y_nxt = '0;
        any_nxt   = 1'b0;
      end else begin
        min_x_nxt = upd_min_x;
        max_x_nxt = upd_max_x;
        min_y_nxt = upd_min_y;
        max_y_nxt = upd_max_y;
        any_nxt   = upd_any;
        // a column past the last one also ends the row (width changed mid-row)
        if (col_r >= last_col_r) begin
          col_nxt = '0;
          if (row_r < LAST_ROW) row_nxt = row_r + coord_t'(1);
        end else begin
          col_nxt = col_r + col_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      min_x_r <= '1;
      max_x_r <= '0;
      min_y_r <= '1;
      max_y_r <= '0;
      any_r   <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      min_x_r <= min_x_nxt;
      max_x_r <= max_x_nxt;
      min_y_r <= min_y_nxt;
      max_y_r <= max_y_nxt;
      any_r   <= any_nxt;
    end
  end

  // centre of the box, zero when nothing was set
  logic [COORD_W:0] sum_x;
  logic [COORD_W:0] sum_y;

  assign sum_x = {1'b0, upd_min_x} + {1'b0, upd_max_x};
  assign sum_y = {1'b0, upd_min_y} + {1'b0, upd_max_y};

  // result register
  logic res_load;
  assign res_load = s1_adv && s1_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_cx_r    <= upd_any ? sum_x[COORD_W:1] : '0;
      out_cy_r    <= upd_any ? sum_y[COORD_W:1] : '0;
      out_found_r <= upd_any;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.mid_x = out_cx_r;
  assign out_ch.mid_y = out_cy_r;
  assign out_ch.found = out_found_r;

  // checks on the running state
  `BIBC_ASSERT_NEXT(a_clear_after_frame, res_load,
    (col_r == '0) && (row_r == '0) && !any_r, "state not cleared after frame end")
  `BIBC_ASSERT_NOW(a_empty_bounds, !any_r,
    (min_x_r == '1) && (max_x_r == '0) && (min_y_r == '1) && (max_y_r == '0),
    "bounds moved with no pixel set")
  `BIBC_ASSERT_NOW(a_ordered_bounds, any_r,
    (min_x_r <= max_x_r) && (min_y_r <= max_y_r), "bounding box inverted")
  `BIBC_ASSERT_NOW(a_row_limit, 1'b1, row_r <= LAST_ROW, "row count past last row")

endmodule

/* sim/bibc_checker.sv */
// checker for the bitmap bounding-box centre block: running-bounds prediction and result compare
`timescale 1ns / 1ps
module bibc_checker
  import bibc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic clk,
  input  logic rst_n,
  bibc_in_if   in_ch,
  bibc_out_if  out_ch,
  bibc_cfg_if  cfg_ch,
  output int   mismatches,
  output int   pending
);

  localparam int unsigned WIDTH_CAP = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int unsigned ROW_TOP   = ((MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096) - 1;

  typedef struct packed {
    coord_t mid_x;
    coord_t mid_y;
    logic   found;
  } centre_t;

  centre_t centre_q[$];
  centre_t want;
  int      fail_count = 0;

  width_t  width_reg;
  col_t    col;
  coord_t  row;
  coord_t  lo_x, hi_x, lo_y, hi_y;
  logic    seen;

  assign mismatches = fail_count;

  task automatic note_fail(input string what, input int got, input int exp_val);
    fail_count++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, exp_val);
  endtask

  function automatic void clear_bounds();
    col  = '0;
    row  = '0;
    lo_x = '1;
    hi_x = '0;
    lo_y = '1;
    hi_y = '0;
    seen = 1'b0;
  endfunction

  // fold one byte into the bounds; a frame_end byte closes the frame
  function automatic void fold_byte(input pix_t pix, input logic fend);
    int unsigned w;
    int unsigned last_c;
    int unsigned x;
    centre_t     res;
    w = (width_reg == '0) ? 1 : int'(width_reg);
    if (w > WIDTH_CAP) w = WIDTH_CAP;
    last_c = ((w + 31) / 32) * 4 - 1;
    for (int b = 0; b < 8; b++) begin
      x = col * 8 + b;
      if (pix[7-b] && x < w) begin
        if (x < lo_x) lo_x = coord_t'(x);
        if (x > hi_x) hi_x = coord_t'(x);
        if (row < lo_y) lo_y = row;
        if (row > hi_y) hi_y = row;
        seen = 1'b1;
      end
    end
    if (col >= last_c) begin
      col = '0;
      if (row < ROW_TOP) row = row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
    if (fend) begin
      res = '0;
      if (seen) begin
        res.mid_x = coord_t'((int'(lo_x) + int'(hi_x)) >> 1);
        res.mid_y = coord_t'((int'(lo_y) + int'(hi_y)) >> 1);
        res.found = 1'b1;
      end
      centre_q.push_back(res);
      clear_bounds();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = RESET_WIDTH;
      clear_bounds();
      centre_q.delete();
      pending <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) width_reg = cfg_ch.width_pixels;
      if (out_ch.valid && out_ch.ready) begin
        if (centre_q.size() == 0) begin
          note_fail("unexpected result", int'(out_ch.mid_x), -1);
        end else begin
          want = centre_q.pop_front();
          if (out_ch.mid_x !== want.mid_x)
            note_fail("mid_x", int'(out_ch.mid_x), int'(want.mid_x));
          if (out_ch.mid_y !== want.mid_y)
            note_fail("mid_y", int'(out_ch.mid_y), int'(want.mid_y));
          if (out_ch.found !== want.found)
            note_fail("found", int'(out_ch.found), int'(want.found));
        end
      end
      if (in_ch.valid && in_ch.ready) fold_byte(in_ch.pixel_byte, in_ch.frame_end);
      pending <= centre_q.size();
    end
  end

endmodule

/* sim/tb.sv */
// testbench top: clock, reset, pixel stream stimulus and verdict for the bbox centre block
`timescale 1ns / 1ps
module tb
  import bibc_pkg::*;
();

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;

  // idle percentages of the sender and the receiver, changed per phase
  int   send_idle = 0;
  int   recv_idle = 0;
  int   sent = 0;
  width_t cur_width = RESET_WIDTH;

  bibc_in_if  in_ch ();
  bibc_out_if out_ch ();
  bibc_cfg_if cfg_ch ();

  binary_image_bbox_center dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bibc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // one byte transfer; random gaps ahead of it, valid stays up afterwards
  task automatic send_byte(input pix_t pix, input logic fend);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pixel_byte <= pix;
    in_ch.frame_end  <= fend;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // stop sending and wait for every outstanding result, then let the pipe settle
  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // width is only rewritten once the block has gone quiet
  task automatic set_width(input width_t w);
    drain(4);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.width_pixels <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_width = w;
  endtask

  // n bytes of one frame, frame_end on the last; fill picks the pixel density
  task automatic send_frame(input int n, input int fill);
    pix_t pix;
    for (int i = 0; i < n; i++) begin
      case (fill)
        0:       pix = '0;
        1:       pix = ($urandom_range(15) == 0) ? pix_t'(8'h80 >> $urandom_range(7)) : '0;
        2:       pix = pix_t'($urandom);
        default: pix = '1;
      endcase
      send_byte(pix, i == n - 1);
    end
  endtask

  // three widths per phase, random frames of a few rows each
  task automatic run_phase(input int s_pct, input int r_pct, input int per_width);
    int unsigned w_eff;
    int          stride;
    int          goal;
    int          n;
    send_idle = s_pct;
    recv_idle = r_pct;
    repeat (3) begin
      case ($urandom_range(7))
        0:       set_width(width_t'(0));
        1:       set_width(width_t'(1));
        2:       set_width(width_t'(8));
        3:       set_width(width_t'(31));
        4:       set_width(width_t'(32));
        5:       set_width(width_t'(33));
        6:       set_width(width_t'(64));
        default: set_width(width_t'($urandom_range(1, 160)));
      endcase
      w_eff  = (cur_width == '0) ? 1 : int'(cur_width);
      if (w_eff > 4096) w_eff = 4096;
      stride = ((w_eff + 31) / 32) * 4;
      goal   = sent + per_width;
      while (sent < goal) begin
        // stray bytes with no frame end just run into the next frame
        if ($urandom_range(99) < 10)
          repeat ($urandom_range(1, 3)) send_byte(pix_t'($urandom), 1'b0);
        n = stride * $urandom_range(1, 4);
        // frame cut short mid-row now and then
        if ($urandom_range(99) < 20) n = $urandom_range(1, n);
        send_frame(n, $urandom_range(3));
        // hold the sender until every result is back
        if ($urandom_range(99) < 4) drain(0);
      end
    end
  endtask

  initial begin
    // every block input known from time zero
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.pixel_byte    = '0;
    in_ch.frame_end     = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.width_pixels = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 29;
    recv_idle = 76;

    // reset width of 32: empty frame, then both row edges, then a full byte
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);

    // width shrinks mid-row: column already past the new last column wraps on the next byte
    set_width(width_t'(100));
    repeat (6) send_byte(8'h00, 1'b0);
    set_width(width_t'(1));
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);

    // zero width behaves as one pixel, padding bits dropped
    set_width(width_t'(0));
    send_byte(8'hff, 1'b1);

    // all width bits set saturates at the widest row; pixels at both ends
    set_width(width_t'(8191));
    send_byte(8'h80, 1'b0);
    repeat (510) send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);

    // random part: sender light, receiver heavy; then swapped; then no idling
    run_phase(29, 76, 75);
    run_phase(76, 29, 75);
    run_phase(0, 0, 75);

    drain(8);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bibc_pkg.sv
rtl/core/bibc_if.sv
rtl/core/binary_image_bbox_center.sv
sim/bibc_checker.sv
sim/tb.sv
